[hdl/fol_pkg.sv]
// Shared constants and types for the frequency-ordered lookup table.
package fol_pkg;

    localparam int FOL_DEPTH       = 64;
    localparam int FOL_KEY_WIDTH   = 32;
    localparam int FOL_COUNT_WIDTH = 16;

    localparam int KEY_PORT_W   = 32;
    localparam int POS_PORT_W   = 6;
    localparam int COUNT_PORT_W = 16;
    localparam int FILL_PORT_W  = 7;

    typedef logic [1:0] t_req;
    typedef logic [1:0] t_status;

    localparam t_req REQ_APPEND = 2'd0;
    localparam t_req REQ_LOCATE = 2'd1;
    localparam t_req REQ_READ   = 2'd2;

    localparam t_status ST_OK        = 2'd0;
    localparam t_status ST_NOT_FOUND = 2'd1;
    localparam t_status ST_FULL      = 2'd2;
    localparam t_status ST_EMPTY     = 2'd3;

endpackage

[hdl/frequency_ordered_lookup_table.sv]
// Frequency-ordered lookup table: sequencer, key/count memory and result register.
//
// Requests arrive on i_valid / o_stall with i_req_type, i_key and i_position; one result
// beat leaves on o_valid / i_stall with status, position, key, count and fill level.
// A request is taken only while the sequencer is idle; o_stall is high from the
// accepting edge until the result has been loaded into the output register.
// Append, no-operation and out-of-range read requests go from idle straight to the
// final state; a read of a held entry passes through a memory read state first. A
// locate reads one entry per cycle from the front until the key matches, then moves
// the entry forward one place per cycle while the neighbour count is less than or equal
// to its own, then writes it back; a single memory port pair serves both the search
// and the reorder.
// The result register frees the sequencer: the next request is taken while a beat
// still waits at the output. If the receiver stalls, the beat holds and a later
// result waits in the final state until the register is free.
// Reset clears the fill level and all handshake state; the memory contents are not
// cleared, as only entries below the fill level are ever read.
module frequency_ordered_lookup_table
    import fol_pkg::*;
#(
    parameter int DEPTH       = FOL_DEPTH,
    parameter int KEY_WIDTH   = FOL_KEY_WIDTH,
    parameter int COUNT_WIDTH = FOL_COUNT_WIDTH
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_valid,
    output logic                     o_stall,
    input  logic [1:0]               i_req_type,
    input  logic signed [31:0]       i_key,
    input  logic [5:0]               i_position,
    output logic                     o_valid,
    input  logic                     i_stall,
    output logic [1:0]               o_status,
    output logic [5:0]               o_position_out,
    output logic signed [31:0]       o_key_out,
    output logic [15:0]              o_count_out,
    output logic [6:0]               o_fill_out
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int FW = $clog2(DEPTH + 1);
    localparam int KS = (KEY_WIDTH < KEY_PORT_W) ? KEY_WIDTH : KEY_PORT_W;
    localparam int CW = COUNT_WIDTH;
    localparam logic [CW-1:0] CMAX = '1;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_SCAN  = 3'd1;
    localparam logic [2:0] S_SHIFT = 3'd2;
    localparam logic [2:0] S_WR    = 3'd3;
    localparam logic [2:0] S_RD    = 3'd4;
    localparam logic [2:0] S_FIN   = 3'd5;

    logic [KS-1:0] key_mem [DEPTH];
    logic [CW-1:0] cnt_mem [DEPTH];

    logic [2:0]              r_state, n_state;
    logic [FW-1:0]           r_fill, n_fill;
    logic [AW-1:0]           r_idx, n_idx;
    logic [AW-1:0]           r_j, n_j;
    logic [KS-1:0]           r_key, n_key;
    logic [CW-1:0]           r_c, n_c;
    t_status                 r_res_st, n_res_st;
    logic [POS_PORT_W-1:0]   r_res_pos, n_res_pos;
    logic [KS-1:0]           r_res_key, n_res_key;
    logic [CW-1:0]           r_res_cnt, n_res_cnt;
    logic                    r_o_valid, n_o_valid;
    t_status                 r_o_st, n_o_st;
    logic [POS_PORT_W-1:0]   r_o_pos, n_o_pos;
    logic [KEY_PORT_W-1:0]   r_o_key, n_o_key;
    logic [COUNT_PORT_W-1:0] r_o_cnt, n_o_cnt;
    logic [FILL_PORT_W-1:0]  r_o_fill, n_o_fill;

    logic [KS-1:0]           r_q_key;
    logic [CW-1:0]           r_q_cnt;
    logic                    we;
    logic [AW-1:0]           w_addr;
    logic [KS-1:0]           w_key;
    logic [CW-1:0]           w_cnt;
    logic [AW-1:0]           rd_addr;
    logic [KS-1:0]           in_key;
    logic                    full;

    assign in_key = KS'($unsigned(i_key));
    assign full   = (r_fill == FW'(DEPTH));

    always_comb begin
        n_state   = r_state;
        n_fill    = r_fill;
        n_idx     = r_idx;
        n_j       = r_j;
        n_key     = r_key;
        n_c       = r_c;
        n_res_st  = r_res_st;
        n_res_pos = r_res_pos;
        n_res_key = r_res_key;
        n_res_cnt = r_res_cnt;
        n_o_valid = r_o_valid && i_stall;
        n_o_st    = r_o_st;
        n_o_pos   = r_o_pos;
        n_o_key   = r_o_key;
        n_o_cnt   = r_o_cnt;
        n_o_fill  = r_o_fill;
        we        = 1'b0;
        w_addr    = r_j;
        w_key     = r_key;
        w_cnt     = r_c;
        rd_addr   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    n_key     = in_key;
                    n_res_key = in_key;
                    n_res_cnt = '0;
                    n_res_pos = '0;
                    n_res_st  = ST_OK;
                    case (i_req_type)
                        REQ_APPEND: begin
                            n_state = S_FIN;
                            if (full) begin
                                n_res_st = ST_FULL;
                            end else begin
                                we        = 1'b1;
                                w_addr    = AW'(r_fill);
                                w_key     = in_key;
                                w_cnt     = '0;
                                n_fill    = r_fill + FW'(1);
                                n_res_pos = POS_PORT_W'(r_fill);
                            end
                        end
                        REQ_LOCATE: begin
                            if (r_fill == '0) begin
                                n_res_st = ST_NOT_FOUND;
                                n_state  = S_FIN;
                            end else begin
                                rd_addr = '0;
                                n_idx   = '0;
                                n_state = S_SCAN;
                            end
                        end
                        REQ_READ: begin
                            n_res_pos = i_position;
                            if (32'(i_position) < 32'(r_fill)) begin
                                rd_addr = AW'(i_position);
                                n_state = S_RD;
                            end else begin
                                n_res_st  = ST_EMPTY;
                                n_res_key = '0;
                                n_state   = S_FIN;
                            end
                        end
                        default: begin
                            n_res_key = '0;
                            n_state   = S_FIN;
                        end
                    endcase
                end
            end
            S_SCAN: begin
                if (r_q_key == r_key) begin
                    n_c = (r_q_cnt == CMAX) ? r_q_cnt : r_q_cnt + CW'(1);
                    if (r_idx == '0) begin
                        n_j     = '0;
                        n_state = S_WR;
                    end else begin
                        rd_addr = r_idx - AW'(1);
                        n_j     = r_idx;
                        n_state = S_SHIFT;
                    end
                end else if (FW'(r_idx) + FW'(1) < r_fill) begin
                    rd_addr = r_idx + AW'(1);
                    n_idx   = r_idx + AW'(1);
                end else begin
                    n_res_st = ST_NOT_FOUND;
                    n_state  = S_FIN;
                end
            end
            S_SHIFT: begin
                if (r_q_cnt <= r_c) begin
                    we     = 1'b1;
                    w_addr = r_j;
                    w_key  = r_q_key;
                    w_cnt  = r_q_cnt;
                    n_j    = r_j - AW'(1);
                    if (r_j != AW'(1)) begin
                        rd_addr = r_j - AW'(2);
                    end else begin
                        n_state = S_WR;
                    end
                end else begin
                    n_state = S_WR;
                end
            end
            S_WR: begin
                we        = 1'b1;
                w_addr    = r_j;
                w_key     = r_key;
                w_cnt     = r_c;
                n_res_st  = ST_OK;
                n_res_pos = POS_PORT_W'(r_j);
                n_res_cnt = r_c;
                n_state   = S_FIN;
            end
            S_RD: begin
                n_res_key = r_q_key;
                n_res_cnt = r_q_cnt;
                n_state   = S_FIN;
            end
            S_FIN: begin
                if (!r_o_valid || !i_stall) begin
                    n_o_valid = 1'b1;
                    n_o_st    = r_res_st;
                    n_o_pos   = r_res_pos;
                    n_o_key   = KEY_PORT_W'(r_res_key);
                    n_o_cnt   = COUNT_PORT_W'(r_res_cnt);
                    n_o_fill  = FILL_PORT_W'(r_fill);
                    n_state   = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (we) begin
            key_mem[w_addr] <= w_key;
            cnt_mem[w_addr] <= w_cnt;
        end
        r_q_key <= key_mem[rd_addr];
        r_q_cnt <= cnt_mem[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_fill    <= '0;
            r_o_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_fill    <= n_fill;
            r_o_valid <= n_o_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx     <= n_idx;
        r_j       <= n_j;
        r_key     <= n_key;
        r_c       <= n_c;
        r_res_st  <= n_res_st;
        r_res_pos <= n_res_pos;
        r_res_key <= n_res_key;
        r_res_cnt <= n_res_cnt;
        r_o_st    <= n_o_st;
        r_o_pos   <= n_o_pos;
        r_o_key   <= n_o_key;
        r_o_cnt   <= n_o_cnt;
        r_o_fill  <= n_o_fill;
    end

    assign o_stall        = (r_state != S_IDLE);
    assign o_valid        = r_o_valid;
    assign o_status       = r_o_st;
    assign o_position_out = r_o_pos;
    assign o_key_out      = $signed(r_o_key);
    assign o_count_out    = r_o_cnt;
    assign o_fill_out     = r_o_fill;

    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_fill) <= DEPTH)
        else $error("fill level beyond depth");

    a_append_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE && i_valid && i_req_type == REQ_APPEND && !full)
        |=> r_fill == $past(r_fill) + FW'(1))
        else $error("append did not advance fill level");

    a_shift_hole: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SHIFT) |-> (r_j != '0 && FW'(r_j) < r_fill))
        else $error("reorder slot out of range");

endmodule

[tb/frequency_ordered_lookup_table_test.sv]
// Self-checking testbench for the frequency-ordered lookup table.
`timescale 1ns / 100ps

module frequency_ordered_lookup_table_test;
    import fol_pkg::*;

    localparam int DEPTH           = FOL_DEPTH;
    localparam int RANDOM_REQUESTS = 600;
    localparam int BURST_LOCATES   = 40;
    localparam int WATCHDOG_LIMIT  = 4000;
    localparam int DRAIN_CYCLES    = 2 * DEPTH + 16;
    localparam int PRINT_CAP       = 50;

    localparam t_req REQ_NONE = 2'd3;
    localparam logic [15:0] COUNT_MAX = '1;
    localparam logic [31:0] EDGE_KEYS [4] = '{32'h0000_0000, 32'h7FFF_FFFF,
                                              32'h8000_0000, 32'hFFFF_FFFF};

    typedef struct packed {
        t_status     status;
        logic [5:0]  position;
        logic [31:0] key;
        logic [15:0] count;
        logic [6:0]  fill;
    } t_lookup_result;

    typedef struct packed {
        t_req           req;
        logic [31:0]    key;
        logic [5:0]     pos;
        logic           typed;
        t_lookup_result result;
    } t_directed_row;

    localparam t_directed_row DIRECTED_ROWS [24] = '{
        '{REQ_READ,   32'h0000_0000, 6'd0,  1'b1, '{ST_EMPTY, 6'd0, 32'h0, 16'd0, 7'd0}},
        '{REQ_READ,   32'hFFFF_FFFF, 6'd63, 1'b1, '{ST_EMPTY, 6'd63, 32'h0, 16'd0, 7'd0}},
        '{REQ_LOCATE, 32'h0000_0005, 6'd21, 1'b1, '{ST_NOT_FOUND, 6'd0, 32'h5, 16'd0, 7'd0}},
        '{REQ_NONE,   32'hFFFF_FFFF, 6'd63, 1'b1, '{ST_OK, 6'd0, 32'h0, 16'd0, 7'd0}},
        '{REQ_APPEND, 32'h8000_0000, 6'd42, 1'b1, '{ST_OK, 6'd0, 32'h8000_0000, 16'd0, 7'd1}},
        '{REQ_APPEND, 32'h7FFF_FFFF, 6'd0,  1'b1, '{ST_OK, 6'd1, 32'h7FFF_FFFF, 16'd0, 7'd2}},
        '{REQ_APPEND, 32'hFFFF_FFFF, 6'd63, 1'b1, '{ST_OK, 6'd2, 32'hFFFF_FFFF, 16'd0, 7'd3}},
        '{REQ_APPEND, 32'h0000_0000, 6'd21, 1'b1, '{ST_OK, 6'd3, 32'h0, 16'd0, 7'd4}},
        '{REQ_LOCATE, 32'h8000_0000, 6'd0,  1'b1, '{ST_OK, 6'd0, 32'h8000_0000, 16'd1, 7'd4}},
        '{REQ_LOCATE, 32'h0000_0000, 6'd0,  1'b0, '0},
        '{REQ_LOCATE, 32'h8000_0000, 6'd0,  1'b0, '0},
        '{REQ_LOCATE, 32'h8000_0000, 6'd0,  1'b0, '0},
        '{REQ_LOCATE, 32'hFFFF_FFFF, 6'd0,  1'b0, '0},
        '{REQ_LOCATE, 32'h7FFF_FFFF, 6'd0,  1'b0, '0},
        '{REQ_LOCATE, 32'h7FFF_FFFF, 6'd0,  1'b0, '0},
        '{REQ_READ,   32'h0000_0000, 6'd0,  1'b0, '0},
        '{REQ_READ,   32'h0000_0000, 6'd1,  1'b0, '0},
        '{REQ_READ,   32'h0000_0000, 6'd2,  1'b0, '0},
        '{REQ_READ,   32'h0000_0000, 6'd3,  1'b0, '0},
        '{REQ_READ,   32'h0000_0000, 6'd4,  1'b1, '{ST_EMPTY, 6'd4, 32'h0, 16'd0, 7'd4}},
        '{REQ_APPEND, 32'h8000_0000, 6'd63, 1'b1, '{ST_OK, 6'd4, 32'h8000_0000, 16'd0, 7'd5}},
        '{REQ_LOCATE, 32'h8000_0000, 6'd0,  1'b0, '0},
        '{REQ_READ,   32'h0000_0000, 6'd4,  1'b0, '0},
        '{REQ_LOCATE, 32'h0000_0001, 6'd0,  1'b1, '{ST_NOT_FOUND, 6'd0, 32'h1, 16'd0, 7'd5}}
    };

    logic        i_clk      = 1'b0;
    logic        i_rst_n    = 1'b0;
    logic        i_valid    = 1'b0;
    logic [1:0]  i_req_type = '0;
    logic [31:0] i_key      = '0;
    logic [5:0]  i_position = '0;
    logic        i_stall    = 1'b0;
    logic        o_stall;
    logic        o_valid;
    logic [1:0]  o_status;
    logic [5:0]  o_position_out;
    logic [31:0] o_key_out;
    logic [15:0] o_count_out;
    logic [6:0]  o_fill_out;

    logic [31:0]    tbl_key [DEPTH];
    logic [15:0]    tbl_count [DEPTH];
    int             tbl_fill = 0;
    t_lookup_result pending_results [$];
    bit             gaps_on = 1'b1;
    int             mismatch_count = 0;
    int             requests_sent = 0;
    int             results_checked = 0;
    int             quiet_cycles = 0;
    int             status_seen [4] = '{0, 0, 0, 0};

    frequency_ordered_lookup_table dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_req_type     (i_req_type),
        .i_key          (i_key),
        .i_position     (i_position),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_status       (o_status),
        .o_position_out (o_position_out),
        .o_key_out      (o_key_out),
        .o_count_out    (o_count_out),
        .o_fill_out     (o_fill_out)
    );

    always #4 i_clk = ~i_clk;

    function automatic t_lookup_result apply_request(input t_req req, input logic [31:0] key,
                                                     input logic [5:0] pos);
        t_lookup_result res;
        int             hit;
        int             dest;
        int             idx;
        logic [15:0]    cnt;
        res = '0;
        case (req)
            REQ_APPEND: begin
                res.key = key;
                if (tbl_fill >= DEPTH) begin
                    res.status = ST_FULL;
                end else begin
                    tbl_key[tbl_fill]   = key;
                    tbl_count[tbl_fill] = '0;
                    res.status          = ST_OK;
                    res.position        = tbl_fill[5:0];
                    tbl_fill++;
                end
            end
            REQ_LOCATE: begin
                hit = -1;
                for (idx = 0; idx < tbl_fill && hit < 0; idx++) begin
                    if (tbl_key[idx] == key) hit = idx;
                end
                res.key = key;
                if (hit < 0) begin
                    res.status = ST_NOT_FOUND;
                end else begin
                    cnt = tbl_count[hit];
                    if (cnt != COUNT_MAX) cnt++;
                    dest = hit;
                    while (dest > 0 && tbl_count[dest - 1] <= cnt) dest--;
                    for (idx = hit; idx > dest; idx--) begin
                        tbl_key[idx]   = tbl_key[idx - 1];
                        tbl_count[idx] = tbl_count[idx - 1];
                    end
                    tbl_key[dest]   = key;
                    tbl_count[dest] = cnt;
                    res.status      = ST_OK;
                    res.position    = dest[5:0];
                    res.count       = cnt;
                end
            end
            REQ_READ: begin
                res.position = pos;
                if (pos < tbl_fill) begin
                    res.status = ST_OK;
                    res.key    = tbl_key[pos];
                    res.count  = tbl_count[pos];
                end else begin
                    res.status = ST_EMPTY;
                end
            end
            default: ;
        endcase
        res.fill = tbl_fill[6:0];
        return res;
    endfunction

    task automatic flag_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
        if (mismatch_count < PRINT_CAP)
            $display("%0t ns: %s mismatch: got %h, expected %h", $time, what, got, want);
        mismatch_count++;
    endtask

    task automatic send_request(input t_req req, input logic [31:0] key, input logic [5:0] pos,
                                input t_lookup_result typed_result, input logic use_typed);
        t_lookup_result predicted;
        while (gaps_on && $urandom_range(99) < 7) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid    <= 1'b1;
        i_req_type <= req;
        i_key      <= key;
        i_position <= pos;
        do @(posedge i_clk); while (o_stall !== 1'b0);
        predicted = apply_request(req, key, pos);
        pending_results.push_back(use_typed ? typed_result : predicted);
        requests_sent++;
    endtask

    task automatic wait_for_results();
        i_valid <= 1'b0;
        do @(posedge i_clk); while (pending_results.size() != 0);
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_stall <= 1'b0;
        end else begin
            i_stall <= gaps_on && ($urandom_range(99) < 7);
        end
    end

    always @(posedge i_clk) begin
        t_lookup_result got;
        t_lookup_result want;
        if (i_rst_n) begin
            if (o_valid === 1'b1 && i_stall === 1'b0) begin
                got = '{o_status, o_position_out, o_key_out, o_count_out, o_fill_out};
                if (pending_results.size() == 0) begin
                    flag_mismatch("unexpected beat, key", got.key, '0);
                end else begin
                    want = pending_results.pop_front();
                    if (got.status !== want.status)
                        flag_mismatch("status", 32'(got.status), 32'(want.status));
                    if (got.position !== want.position)
                        flag_mismatch("position", 32'(got.position), 32'(want.position));
                    if (got.key !== want.key)
                        flag_mismatch("key", got.key, want.key);
                    if (got.count !== want.count)
                        flag_mismatch("count", 32'(got.count), 32'(want.count));
                    if (got.fill !== want.fill)
                        flag_mismatch("fill", 32'(got.fill), 32'(want.fill));
                    status_seen[want.status]++;
                    results_checked++;
                end
            end
            if ((i_valid && o_stall === 1'b0) || (o_valid === 1'b1 && i_stall === 1'b0)) begin
                quiet_cycles <= 0;
            end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("%0t ns: no beat for %0d cycles", $time, WATCHDOG_LIMIT);
                $display("** frequency_ordered_lookup_table: FAILED **");
                $finish;
            end else begin
                quiet_cycles <= quiet_cycles + 1;
            end
        end
    end

    initial begin
        int          n;
        int          pick;
        int          roll;
        t_req        req;
        logic [31:0] key;
        logic [5:0]  pos;
        logic [31:0] sat_front;
        logic [31:0] sat_second;

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (DIRECTED_ROWS[r])
            send_request(DIRECTED_ROWS[r].req, DIRECTED_ROWS[r].key, DIRECTED_ROWS[r].pos,
                         DIRECTED_ROWS[r].result, DIRECTED_ROWS[r].typed);
        wait_for_results();

        // hammer the two leading entries with no gaps until the second overtakes the first
        gaps_on    = 1'b0;
        sat_front  = tbl_key[0];
        sat_second = tbl_key[1];
        repeat (BURST_LOCATES) send_request(REQ_LOCATE, sat_front, 6'd0, '0, 1'b0);
        while (tbl_key[0] != sat_second) send_request(REQ_LOCATE, sat_second, 6'd0, '0, 1'b0);
        send_request(REQ_LOCATE, sat_second, 6'd0, '0, 1'b0);
        send_request(REQ_LOCATE, sat_front, 6'd0, '0, 1'b0);
        for (n = 0; n < 3; n++) send_request(REQ_READ, 32'h0, n[5:0], '0, 1'b0);
        wait_for_results();
        gaps_on = 1'b1;

        for (n = 0; n < RANDOM_REQUESTS; n++) begin
            pick = $urandom_range(99);
            key  = $urandom;
            pos  = 6'($urandom_range(63));
            if (pick < ((tbl_fill < DEPTH) ? 30 : 6)) begin
                req  = REQ_APPEND;
                roll = $urandom_range(99);
                if (roll < 8) begin
                    key = EDGE_KEYS[$urandom_range(3)];
                end else if (roll < 20 && tbl_fill > 0) begin
                    key = tbl_key[$urandom_range(tbl_fill - 1)];
                end
            end else if (pick < 80) begin
                req = REQ_LOCATE;
                if ($urandom_range(99) < 85 && tbl_fill > 0)
                    key = tbl_key[$urandom_range(tbl_fill - 1)];
            end else if (pick < 96) begin
                req = REQ_READ;
                if ($urandom_range(99) < 80 && tbl_fill > 0)
                    pos = 6'($urandom_range(tbl_fill - 1));
            end else begin
                req = REQ_NONE;
            end
            send_request(req, key, pos, '0, 1'b0);
            if (n % 150 == 149) wait_for_results();
        end

        wait_for_results();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (pending_results.size() != 0)
            flag_mismatch("left over results", pending_results.size(), '0);

        $display("Covered %0d requests: directed table, gapless locate burst on two leading",
                 requests_sent);
        $display("entries, random mix to fill %0d; %0d results (ok/missing/full/empty %0d/%0d/%0d/%0d)",
                 tbl_fill, results_checked, status_seen[ST_OK], status_seen[ST_NOT_FOUND],
                 status_seen[ST_FULL], status_seen[ST_EMPTY]);
        if (mismatch_count == 0) begin
            $display("** frequency_ordered_lookup_table: PASSED **");
        end else begin
            $display("** frequency_ordered_lookup_table: FAILED **");
        end
        $finish;
    end

endmodule

[files.f]
hdl/fol_pkg.sv
hdl/frequency_ordered_lookup_table.sv
tb/frequency_ordered_lookup_table_test.sv
